// ===== rtl/core/ntl_pkg.sv =====
// shared types and constants of the thermistor linearizer
`default_nettype none
package ntl_pkg;
  localparam int EXP_W  = 4;
  localparam int FRAC_W = 30;
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam int DIV_QW = 18;
  localparam int SUM_W  = 61;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_CELSIUS   = 3'd1;
  localparam logic [2:0] REG_COEFF_A   = 3'd2;
  localparam logic [2:0] REG_COEFF_B   = 3'd3;
  localparam logic [2:0] REG_COEFF_C   = 3'd4;
  localparam logic [2:0] REG_COEFF_D   = 3'd5;
  localparam logic [2:0] REG_THRESHOLD = 3'd6;

  localparam logic [47:0] COEFF_A_RST = 48'd3687779592;
  localparam logic [47:0] COEFF_B_RST = 48'd282051121;
  localparam logic [47:0] COEFF_C_RST = 48'd2865294;
  localparam logic [47:0] COEFF_D_RST = 48'd69591;
  localparam logic [15:0] THRESH_RST  = 16'd100;

  localparam logic [31:0] LN2_Q30     = 32'd744261118;
  localparam logic [59:0] DIV_NUM     = 60'd100 << 40;
  localparam logic signed [18:0] K_OFFSET = 19'sd27315;
  localparam logic signed [18:0] OUT_MIN  = -19'sd27315;
  localparam logic signed [18:0] OUT_MAX  = 19'sd65535;

  typedef struct packed {
    logic        start;
    logic [59:0] num;
    logic [59:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] q;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/ntl_if.sv =====
// handshake channels of the thermistor linearizer
`default_nettype none
interface ntl_in_if #(parameter int W = 10) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] adc_sample;
  modport source (output valid, adc_sample, input ready);
  modport sink (input valid, adc_sample, output ready);
endinterface

interface ntl_out_if ();
  logic               valid;
  logic               ready;
  logic signed [16:0] temperature;
  logic               changed;
  logic               sample_invalid;
  modport source (output valid, temperature, changed, sample_invalid, input ready);
  modport sink (input valid, temperature, changed, sample_invalid, output ready);
endinterface

interface ntl_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [47:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ntl_mul.sv =====
// shared registered 32x32 multiplier
`default_nettype none
module ntl_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire

// ===== rtl/core/ntl_div.sv =====
// restoring divider giving an 18-bit quotient with overflow flag
`default_nettype none
module ntl_div
  import ntl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [59:0]       rem_r, den_r;
  logic [DIV_QW-1:0] q_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r, ovf_r;
  logic [79:0]       sub;
  logic              ge;

  always_comb begin
    sub = 80'(den_r) << cnt_r;
    ge  = 80'(rem_r) >= sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rem_r  <= req.num;
        den_r  <= req.den;
        q_r    <= '0;
        cnt_r  <= 5'(DIV_QW);
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == 5'(DIV_QW)) begin
          if (ge) begin
            ovf_r  <= 1'b1;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          cnt_r <= cnt_r - 5'd1;
        end else begin
          if (ge) begin
            rem_r <= rem_r - sub[59:0];
            q_r   <= q_r | (DIV_QW'(1) << cnt_r);
          end
          if (cnt_r == 5'd0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.q    = q_r;
endmodule
`default_nettype wire

// ===== rtl/core/ntc_thermistor_linearizer.sv =====
// ntc thermistor linearizer: log, steinhart-hart sum, reciprocal, change detect
//   channel  dir  payload
//   in_ch    in   adc_sample
//   out_ch   out  temperature, changed, sample_invalid
//   cfg_ch   in   reg_index, wdata
// each item runs two log loops and six multiply jobs on the shared multiplier,
// then the divider unless the sum is zero or negative
// a zero sample goes from idle straight to the done state
// rst_n is synchronous; config is always ready, one item in flight at a time
// a finished result waits in the output register while the next item is taken
`default_nettype none
module ntc_thermistor_linearizer
  import ntl_pkg::*;
#(
  parameter int ADC_WIDTH = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ntl_in_if.sink    in_ch,
  ntl_out_if.source out_ch,
  ntl_cfg_if.sink   cfg_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOGA = 7'b0000010,
    S_LOGB = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIVS = 7'b0010000,
    S_DIVW = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t st_r;
  logic              en_r, cel_r;
  logic [47:0]       ca_r, cb_r, cc_r, cd_r;
  logic [15:0]       thr_r;
  logic signed [17:0] last_r;

  logic [ADC_WIDTH-1:0] n_r;
  logic [4:0]        cnt_r;
  logic [EXP_W-1:0]  e_r;
  logic [FRAC_W-1:0] frac_r;
  logic [LOG_W-1:0]  la_r;
  logic [LOG_W:0]    d_r;
  logic [2:0]        job_r;
  logic [1:0]        ph_r;
  logic [63:0]       acc_r;
  logic [24:0]       lq_r;
  logic [31:0]       l2_r;
  logic [32:0]       l3_r;
  logic [SUM_W-1:0]  s_r;
  logic signed [16:0] res_t_r;
  logic              res_inv_r;

  logic               out_valid_r;
  logic signed [16:0] out_t_r;
  logic               out_chg_r, out_inv_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] p_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  ntl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));
  ntl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // log datapath
  logic [ADC_WIDTH-1:0] v_sel;
  logic [EXP_W-1:0]     e_c;
  logic [31:0]          m_init, m_next;
  logic [32:0]          sq;
  logic                 bit_c;
  logic [LOG_W-1:0]     log_val;

  always_comb begin
    v_sel = st_r[1] ? n_r : ADC_WIDTH'(0) - n_r;
    e_c = '0;
    for (int i = 0; i < ADC_WIDTH; i++) begin
      if (v_sel[i]) e_c = EXP_W'(i);
    end
    m_init  = 32'(v_sel) << (5'd31 - 5'(e_c));
    sq      = p_r[63:31];
    bit_c   = sq[32];
    m_next  = bit_c ? sq[32:1] : sq[31:0];
    log_val = {e_r, frac_r[FRAC_W-2:0], bit_c};
  end

  // multiply job operands
  logic [47:0] xm;
  logic [31:0] ym;
  logic        neg;
  logic [23:0] lqm;
  logic [31:0] l3m;
  logic [33:0] dm;
  logic [79:0] full;
  logic [59:0] term;

  always_comb begin
    lqm  = lq_r[24] ? 24'(25'(0) - lq_r) : lq_r[23:0];
    l3m  = l3_r[32] ? 32'(33'(0) - l3_r) : l3_r[31:0];
    dm   = d_r[LOG_W] ? 34'(35'(0) - d_r) : d_r[33:0];
    xm   = '0;
    ym   = '0;
    neg  = 1'b0;
    unique case (job_r)
      3'd0: begin
        xm = 48'(dm); ym = LN2_Q30; neg = d_r[LOG_W];
      end
      3'd1: begin
        xm = 48'(lqm); ym = 32'(lqm);
      end
      3'd2: begin
        xm = 48'(l2_r); ym = 32'(lqm); neg = lq_r[24];
      end
      3'd3: begin
        xm = cb_r[47] ? 48'(0) - cb_r : cb_r; ym = 32'(lqm); neg = cb_r[47] ^ lq_r[24];
      end
      3'd4: begin
        xm = cc_r[47] ? 48'(0) - cc_r : cc_r; ym = l2_r; neg = cc_r[47];
      end
      3'd5: begin
        xm = cd_r[47] ? 48'(0) - cd_r : cd_r; ym = l3m; neg = cd_r[47] ^ l3_r[32];
      end
      default: begin
        xm = '0; ym = '0; neg = 1'b0;
      end
    endcase
    full = 80'(acc_r) + {p_r[47:0], 32'b0};
    term = full[79:20];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == S_LOGA || st_r == S_LOGB) begin
      mul_a = (cnt_r == 5'd0) ? m_init : m_next;
      mul_b = mul_a;
    end else if (st_r == S_MUL) begin
      mul_a = (ph_r == 2'd0) ? xm[31:0] : 32'(xm[47:32]);
      mul_b = ym;
    end
  end

  // reciprocal result and clamp
  logic signed [18:0] tk, tcl;
  always_comb begin
    tk = $signed({1'b0, drsp.q});
    if (cel_r) tk = tk - K_OFFSET;
    priority if (drsp.ovf)   tcl = OUT_MAX;
    else if (tk > OUT_MAX)   tcl = OUT_MAX;
    else if (tk < OUT_MIN)   tcl = OUT_MIN;
    else                     tcl = tk;
  end

  assign dreq.start = (st_r == S_DIVS) && !s_r[SUM_W-1] && (s_r != '0);
  assign dreq.num   = DIV_NUM + {1'b0, s_r[59:1]};
  assign dreq.den   = s_r[59:0];

  // change detect at output load
  logic signed [18:0] diff;
  logic [17:0]        adiff;
  logic               chg;
  logic               load;
  always_comb begin
    diff  = 19'(last_r) - 19'(res_t_r);
    adiff = diff[18] ? 18'(19'(0) - diff) : diff[17:0];
    chg   = en_r && !res_inv_r && (adiff >= 18'(thr_r));
    load  = (st_r == S_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.temperature    = out_t_r;
  assign out_ch.changed        = out_chg_r;
  assign out_ch.sample_invalid = out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      cel_r <= 1'b1;
      ca_r  <= COEFF_A_RST;
      cb_r  <= COEFF_B_RST;
      cc_r  <= COEFF_C_RST;
      cd_r  <= COEFF_D_RST;
      thr_r <= THRESH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_ENABLE:    en_r  <= cfg_ch.wdata[0];
        REG_CELSIUS:   cel_r <= cfg_ch.wdata[0];
        REG_COEFF_A:   ca_r  <= cfg_ch.wdata;
        REG_COEFF_B:   cb_r  <= cfg_ch.wdata;
        REG_COEFF_C:   cc_r  <= cfg_ch.wdata;
        REG_COEFF_D:   cd_r  <= cfg_ch.wdata;
        REG_THRESHOLD: thr_r <= cfg_ch.wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && !load) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            n_r   <= in_ch.adc_sample[ADC_WIDTH-1:0];
            cnt_r <= '0;
            if (in_ch.adc_sample[ADC_WIDTH-1:0] == '0) begin
              res_inv_r <= 1'b1;
              res_t_r   <= '0;
              st_r      <= S_DONE;
            end else begin
              res_inv_r <= 1'b0;
              st_r      <= S_LOGA;
            end
          end
        end
        S_LOGA, S_LOGB: begin
          if (cnt_r == 5'd0) begin
            e_r <= e_c;
          end else begin
            frac_r <= {frac_r[FRAC_W-2:0], bit_c};
          end
          if (cnt_r == 5'(FRAC_W)) begin
            cnt_r <= '0;
            if (st_r == S_LOGA) begin
              la_r <= log_val;
              st_r <= S_LOGB;
            end else begin
              d_r   <= {1'b0, la_r} - {1'b0, log_val};
              s_r   <= SUM_W'($signed(ca_r));
              job_r <= '0;
              ph_r  <= '0;
              st_r  <= S_MUL;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MUL: begin
          unique case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              acc_r <= p_r;
              ph_r  <= 2'd2;
            end
            default: begin
              ph_r <= 2'd0;
              unique case (job_r)
                3'd0: lq_r <= neg ? 25'(0) - {1'b0, full[63:40]} : {1'b0, full[63:40]};
                3'd1: l2_r <= full[51:20];
                3'd2: l3_r <= neg ? 33'(0) - {1'b0, full[51:20]} : {1'b0, full[51:20]};
                default: s_r <= neg ? s_r - SUM_W'(term) : s_r + SUM_W'(term);
              endcase
              if (job_r == 3'd5) begin
                st_r <= S_DIVS;
              end else begin
                job_r <= job_r + 3'd1;
              end
            end
          endcase
        end
        S_DIVS: begin
          if (s_r[SUM_W-1] || s_r == '0) begin
            res_t_r <= 17'(OUT_MAX);
            st_r    <= S_DONE;
          end else begin
            st_r <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            res_t_r <= 17'(tcl);
            st_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            out_valid_r <= 1'b1;
            out_t_r     <= res_t_r;
            out_inv_r   <= res_inv_r;
            out_chg_r   <= chg;
            if (chg) last_r <= 18'(res_t_r);
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.adc_sample == '0) |=> st_r == S_DONE)
    else $error("zero sample did not finish at once");
  a_invalid_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_t_r == '0 && !out_chg_r))
    else $error("invalid item carries data");
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chg_r) |-> last_r == 18'(out_t_r))
    else $error("last reported not updated");
  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> st_r == S_DIVW)
    else $error("divider result outside wait state");
`endif
endmodule
`default_nettype wire
